### sv/assert_macros.svh
// Assertion macros for the segment descriptor allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every aclk edge outside reset
`define SDA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("segment descriptor allocator: assertion failed");

// Check a property on every aclk edge, reset included
`define SDA_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("segment descriptor allocator: assertion failed");

`else

`define SDA_ASSERT(lbl, prop)
`define SDA_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

### sv/sda_pkg.sv
// Shared types, codes and descriptor helpers of the segment descriptor allocator
`default_nettype none

package sda_pkg;

    // Field widths
    localparam int SLOT_W       = 11;
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int WORD_IDX_W   = SLOT_W - BIT_W;

    // Action codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_WRITE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Descriptor constants
    localparam logic [7:0]  ACC_KERNEL_CODE = 8'h9A;
    localparam logic [7:0]  ACC_KERNEL_DATA = 8'h92;
    localparam logic [7:0]  ACC_USER_CODE   = 8'hFA;
    localparam logic [7:0]  ACC_USER_DATA   = 8'hF2;
    localparam logic [7:0]  FLAGS_PAGE32    = 8'hCF;
    localparam logic [31:0] FLAT_LIMIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] FLAT_BASE       = 32'h0000_0000;

    // Flat entries present after reset
    localparam logic [31:0] ENT_KERNEL_CODE = 32'd1;
    localparam logic [31:0] ENT_KERNEL_DATA = 32'd2;
    localparam logic [31:0] ENT_USER_CODE   = 32'd3;
    localparam logic [31:0] ENT_USER_DATA   = 32'd4;

    // First table entry of the allocated pairs
    localparam logic [31:0] PAIR_FIRST_ENTRY = 32'd6;

    // Request from the sequencer to the slot map
    typedef struct packed {
        logic              alloc;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } slot_req_t;

    // Completion from the slot map
    typedef struct packed {
        logic              done;
        logic              full;
        logic [SLOT_W-1:0] slot;
    } slot_rsp_t;

    // Pack one 64-bit x86 segment descriptor
    function automatic logic [63:0] pack_descriptor(
        input logic [31:0] base,
        input logic [31:0] limit,
        input logic [7:0]  access,
        input logic [7:0]  flags
    );
        return {base[31:24], flags[7:4], limit[19:16], access, base[23:0], limit[15:0]};
    endfunction

    // Extract the 32-bit base of a descriptor
    function automatic logic [31:0] descriptor_base(input logic [63:0] desc);
        return {desc[63:56], desc[39:16]};
    endfunction

    // Contents of a table entry after reset
    function automatic logic [63:0] init_entry(input logic [31:0] entry);
        logic [63:0] d;
        case (entry)
            ENT_KERNEL_CODE: d = pack_descriptor(FLAT_BASE, FLAT_LIMIT, ACC_KERNEL_CODE,
                                                 FLAGS_PAGE32);
            ENT_KERNEL_DATA: d = pack_descriptor(FLAT_BASE, FLAT_LIMIT, ACC_KERNEL_DATA,
                                                 FLAGS_PAGE32);
            ENT_USER_CODE:   d = pack_descriptor(FLAT_BASE, FLAT_LIMIT, ACC_USER_CODE,
                                                 FLAGS_PAGE32);
            ENT_USER_DATA:   d = pack_descriptor(FLAT_BASE, FLAT_LIMIT, ACC_USER_DATA,
                                                 FLAGS_PAGE32);
            default:         d = '0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

### sv/sda_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data
`default_nettype none

module sda_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and read in the same cycle; read data lands on the next edge
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/sda_slot_map.sv
// Free map of descriptor pairs: word RAM with a summary of words holding free slots
`default_nettype none

module sda_slot_map #(
    parameter int GRANT_SLOTS = 2045
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sda_pkg::slot_req_t req,
    output sda_pkg::slot_rsp_t     rsp
);

    localparam int WB         = sda_pkg::WORD_BITS;
    localparam int SLOT_WORDS = (GRANT_SLOTS + WB - 1) / WB;
    localparam int WAW        = (SLOT_WORDS > 1) ? $clog2(SLOT_WORDS) : 1;

    typedef enum logic {
        MS_IDLE,
        MS_CHECK
    } map_state_t;

    map_state_t                     state_reg;
    logic                           op_alloc_reg;
    logic [WAW-1:0]                 word_reg;
    logic [sda_pkg::BIT_W-1:0]      bit_reg;
    logic [SLOT_WORDS-1:0]          avail_reg;
    logic [SLOT_WORDS-1:0]          valid_reg;
    sda_pkg::slot_rsp_t             rsp_reg;

    logic [WAW-1:0]                 first_avail;
    logic                           any_avail;
    logic [sda_pkg::WORD_IDX_W-1:0] req_word;
    logic [WAW-1:0]                 rd_addr;
    logic [WB-1:0]                  rd_data;
    logic [WB-1:0]                  elig;
    logic [WB-1:0]                  cur_word;
    logic [WB-1:0]                  free_bits;
    logic [sda_pkg::BIT_W-1:0]      low_free;
    logic [WB-1:0]                  new_word;
    logic                           new_avail;
    logic                           wr_en;

    // Lowest word that still holds a free slot
    always_comb begin
        first_avail = '0;
        for (int w = SLOT_WORDS - 1; w >= 0; w--) begin
            if (avail_reg[w]) begin
                first_avail = WAW'(w);
            end
        end
    end

    assign any_avail = |avail_reg;
    assign req_word  = req.free_slot[sda_pkg::SLOT_W-1:sda_pkg::BIT_W];
    assign rd_addr   = req.alloc ? first_avail : req_word[WAW-1:0];

    // Slots of the current word that may be granted
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            elig[b] = ((int'(word_reg) * WB + b) < GRANT_SLOTS);
        end
    end

    // A word never written reads as all free
    assign cur_word  = valid_reg[word_reg] ? rd_data : '0;
    assign free_bits = ~cur_word & elig;

    // Lowest free slot within the word
    always_comb begin
        low_free = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                low_free = sda_pkg::BIT_W'(b);
            end
        end
    end

    assign new_word  = op_alloc_reg ? (cur_word | (WB'(1) << low_free))
                                    : (cur_word & ~(WB'(1) << bit_reg));
    assign new_avail = |(~new_word & elig);
    assign wr_en     = (state_reg == MS_CHECK);

    sda_ram #(
        .WIDTH (WB),
        .DEPTH (SLOT_WORDS)
    ) u_word_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (word_reg),
        .wdata (new_word),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Sequence read, modify and write back of one map word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= MS_IDLE;
            avail_reg    <= '1;
            valid_reg    <= '0;
            rsp_reg      <= '0;
            op_alloc_reg <= 1'b0;
            word_reg     <= '0;
            bit_reg      <= '0;
        end else begin
            case (state_reg)
                MS_IDLE: begin
                    rsp_reg.done <= req.alloc && !any_avail;
                    if (req.alloc) begin
                        if (!any_avail) begin
                            rsp_reg.full <= 1'b1;
                            rsp_reg.slot <= '0;
                        end else begin
                            op_alloc_reg <= 1'b1;
                            word_reg     <= first_avail;
                            state_reg    <= MS_CHECK;
                        end
                    end else if (req.free) begin
                        op_alloc_reg <= 1'b0;
                        word_reg     <= req_word[WAW-1:0];
                        bit_reg      <= req.free_slot[sda_pkg::BIT_W-1:0];
                        state_reg    <= MS_CHECK;
                    end
                end
                MS_CHECK: begin
                    avail_reg[word_reg] <= new_avail;
                    valid_reg[word_reg] <= 1'b1;
                    rsp_reg.done        <= 1'b1;
                    rsp_reg.full        <= 1'b0;
                    rsp_reg.slot        <= op_alloc_reg
                                           ? {sda_pkg::WORD_IDX_W'(word_reg), low_free}
                                           : '0;
                    state_reg           <= MS_IDLE;
                end
                default: begin
                    rsp_reg.done <= 1'b0;
                    state_reg    <= MS_IDLE;
                end
            endcase
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

### sv/segment_descriptor_allocator.sv
// Each item goes from ST_IDLE to ST_DONE: a read via ST_READ, one that uses the slot map
// via ST_SLOT, a granted alloc then via ST_CODE and ST_DATA, any other item directly. The
// next item is taken the cycle after its result is registered; the pace is set by the
// slot map read-modify-write and the two descriptor writes through the table's single
// write port. After reset a clearing pass writes all TABLE_ENTRIES entries, one per cycle,
// with s_tready low; the slot map needs no pass, its words carry valid bits.
`default_nettype none

`include "assert_macros.svh"

module segment_descriptor_allocator #(
    parameter int SLOT_COUNT    = 2045,
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // base[31:0], limit[63:32], index[75:64], selector[91:76],
    // access_byte[99:92], flag_byte[107:100], zero[111:108]
    input  wire logic [111:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], slot[12:2], base_out[44:13], zero[47:45]
    output logic [47:0]       m_tdata
);

    localparam int HALF_SPAN   = (TABLE_ENTRIES - 6) / 2;
    localparam int GRANT_SLOTS = (SLOT_COUNT < HALF_SPAN) ? SLOT_COUNT : HALF_SPAN;
    localparam int AW          = $clog2(TABLE_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_CODE,
        ST_DATA,
        ST_READ,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [AW-1:0]              clr_reg;
    logic [1:0]                 act_reg;
    logic [31:0]                base_reg;
    logic [31:0]                limit_reg;
    logic [sda_pkg::SLOT_W-1:0] slot_reg;
    logic [1:0]                 status_reg;
    logic [31:0]                base_res_reg;
    logic                       m_valid_reg;
    logic [47:0]                m_data_reg;

    logic [1:0]         in_action;
    logic [31:0]        in_base;
    logic [31:0]        in_limit;
    logic [11:0]        in_index;
    logic [15:0]        in_selector;
    logic [7:0]         in_access;
    logic [7:0]         in_flags;
    logic [31:0]        in_index32;
    logic [31:0]        in_entry32;
    logic               accept;
    logic               idx_in_table;
    logic               entry_in_table;
    logic [31:0]        code_entry32;
    logic [31:0]        data_entry32;

    logic               tbl_we;
    logic [AW-1:0]      tbl_waddr;
    logic [63:0]        tbl_wdata;
    logic [63:0]        tbl_rdata;

    sda_pkg::slot_req_t slot_req;
    sda_pkg::slot_rsp_t slot_rsp;

    // Unpack the input transfer
    assign in_action   = s_tuser;
    assign in_base     = s_tdata[31:0];
    assign in_limit    = s_tdata[63:32];
    assign in_index    = s_tdata[75:64];
    assign in_selector = s_tdata[91:76];
    assign in_access   = s_tdata[99:92];
    assign in_flags    = s_tdata[107:100];

    assign in_index32     = 32'(in_index);
    assign in_entry32     = 32'(in_selector >> 3);
    assign idx_in_table   = (in_index32 < 32'(TABLE_ENTRIES));
    assign entry_in_table = (in_entry32 < 32'(TABLE_ENTRIES));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Entries of the granted pair
    assign code_entry32 = (32'(slot_reg) << 1) + sda_pkg::PAIR_FIRST_ENTRY;
    assign data_entry32 = code_entry32 + 32'd1;

    // Slot map requests go out with the input transfer
    assign slot_req.alloc     = accept && (in_action == sda_pkg::ACT_ALLOC);
    assign slot_req.free      = accept && (in_action == sda_pkg::ACT_FREE)
                                && (in_index32 < 32'(GRANT_SLOTS));
    assign slot_req.free_slot = in_index[sda_pkg::SLOT_W-1:0];

    // Select the table write: clearing pass, direct write or pair writes
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = in_index32[AW-1:0];
        tbl_wdata = sda_pkg::pack_descriptor(in_base, in_limit, in_access, in_flags);
        case (state_reg)
            ST_CLEAR: begin
                tbl_we    = 1'b1;
                tbl_waddr = clr_reg;
                tbl_wdata = sda_pkg::init_entry(32'(clr_reg));
            end
            ST_IDLE: begin
                tbl_we = accept && (in_action == sda_pkg::ACT_WRITE) && idx_in_table;
            end
            ST_CODE: begin
                tbl_we    = 1'b1;
                tbl_waddr = code_entry32[AW-1:0];
                tbl_wdata = sda_pkg::pack_descriptor(base_reg, limit_reg,
                                                     sda_pkg::ACC_USER_CODE,
                                                     sda_pkg::FLAGS_PAGE32);
            end
            ST_DATA: begin
                tbl_we    = 1'b1;
                tbl_waddr = data_entry32[AW-1:0];
                tbl_wdata = sda_pkg::pack_descriptor(base_reg, limit_reg,
                                                     sda_pkg::ACC_USER_DATA,
                                                     sda_pkg::FLAGS_PAGE32);
            end
            default: begin
                tbl_we = 1'b0;
            end
        endcase
    end

    sda_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_ENTRIES)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (in_entry32[AW-1:0]),
        .rdata (tbl_rdata)
    );

    sda_slot_map #(
        .GRANT_SLOTS (GRANT_SLOTS)
    ) u_slot_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (slot_req),
        .rsp     (slot_rsp)
    );

    // Sequence each item and hold its result in the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop a taken result unless a new one replaces it below
            if (m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(TABLE_ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        act_reg      <= in_action;
                        base_reg     <= in_base;
                        limit_reg    <= in_limit;
                        slot_reg     <= '0;
                        status_reg   <= sda_pkg::ST_OK;
                        base_res_reg <= '0;
                        case (in_action)
                            sda_pkg::ACT_ALLOC: begin
                                state_reg <= ST_SLOT;
                            end
                            sda_pkg::ACT_FREE: begin
                                if (in_index32 >= 32'(SLOT_COUNT)) begin
                                    status_reg <= sda_pkg::ST_RANGE;
                                    state_reg  <= ST_DONE;
                                end else if (slot_req.free) begin
                                    state_reg <= ST_SLOT;
                                end else begin
                                    state_reg <= ST_DONE;
                                end
                            end
                            sda_pkg::ACT_READ: begin
                                if (entry_in_table) begin
                                    state_reg <= ST_READ;
                                end else begin
                                    status_reg <= sda_pkg::ST_RANGE;
                                    state_reg  <= ST_DONE;
                                end
                            end
                            sda_pkg::ACT_WRITE: begin
                                if (!idx_in_table) begin
                                    status_reg <= sda_pkg::ST_RANGE;
                                end
                                state_reg <= ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SLOT: begin
                    if (slot_rsp.done) begin
                        if (act_reg != sda_pkg::ACT_ALLOC) begin
                            state_reg <= ST_DONE;
                        end else if (slot_rsp.full) begin
                            status_reg <= sda_pkg::ST_FULL;
                            state_reg  <= ST_DONE;
                        end else begin
                            slot_reg  <= slot_rsp.slot;
                            state_reg <= ST_CODE;
                        end
                    end
                end
                ST_CODE: begin
                    state_reg <= ST_DATA;
                end
                ST_DATA: begin
                    state_reg <= ST_DONE;
                end
                ST_READ: begin
                    base_res_reg <= sda_pkg::descriptor_base(tbl_rdata);
                    state_reg    <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {3'b000, base_res_reg, slot_reg, status_reg};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Slot map completes only while the sequencer waits for it
    `SDA_ASSERT(a_rsp_when_waiting, slot_rsp.done |-> (state_reg == ST_SLOT))
    // A granted slot always has its whole pair inside the table
    `SDA_ASSERT(a_grant_in_range,
                (slot_rsp.done && !slot_rsp.full) |-> (32'(slot_rsp.slot) < 32'(GRANT_SLOTS)))
    // One item at a time: an input transfer closes the input side
    `SDA_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready)

endmodule

`default_nettype wire

### verif/sda_checker.sv
`timescale 1ns / 1ps
// Checker for the segment descriptor allocator: mirrors the slot map and table, compares results
module sda_checker #(
    parameter int SLOT_COUNT    = 2045,
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [111:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [47:0]  m_tdata,
    output int                mismatches,
    output int                pending,
    output int                results_seen,
    output int                slots_granted,
    output int                full_answers,
    output int                range_answers
);

    localparam int SAW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int TAW = $clog2(TABLE_ENTRIES);

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] slot;
        logic [31:0] base_out;
    } outcome_t;

    // Mirror of the block's state
    logic        slot_taken [SLOT_COUNT];
    logic [63:0] gdt [TABLE_ENTRIES];

    // Outcomes of accepted requests, oldest first
    outcome_t awaited_outcomes[$];

    // Lay out one 64-bit segment descriptor
    function automatic logic [63:0] build_descriptor(input logic [31:0] seg_base,
                                                     input logic [31:0] seg_limit,
                                                     input logic [7:0] acc,
                                                     input logic [7:0] flg);
        logic [63:0] d;
        d        = '0;
        d[15:0]  = seg_limit[15:0];
        d[39:16] = seg_base[23:0];
        d[47:40] = acc;
        d[51:48] = seg_limit[19:16];
        d[55:52] = flg[7:4];
        d[63:56] = seg_base[31:24];
        return d;
    endfunction

    // Free every slot; zero the table apart from the four flat entries
    function automatic void clear_model();
        foreach (slot_taken[i]) slot_taken[i] = 1'b0;
        foreach (gdt[i]) gdt[i] = '0;
        gdt[TAW'(sda_pkg::ENT_KERNEL_CODE)] =
            build_descriptor(sda_pkg::FLAT_BASE, sda_pkg::FLAT_LIMIT,
                             sda_pkg::ACC_KERNEL_CODE, sda_pkg::FLAGS_PAGE32);
        gdt[TAW'(sda_pkg::ENT_KERNEL_DATA)] =
            build_descriptor(sda_pkg::FLAT_BASE, sda_pkg::FLAT_LIMIT,
                             sda_pkg::ACC_KERNEL_DATA, sda_pkg::FLAGS_PAGE32);
        gdt[TAW'(sda_pkg::ENT_USER_CODE)] =
            build_descriptor(sda_pkg::FLAT_BASE, sda_pkg::FLAT_LIMIT,
                             sda_pkg::ACC_USER_CODE, sda_pkg::FLAGS_PAGE32);
        gdt[TAW'(sda_pkg::ENT_USER_DATA)] =
            build_descriptor(sda_pkg::FLAT_BASE, sda_pkg::FLAT_LIMIT,
                             sda_pkg::ACC_USER_DATA, sda_pkg::FLAGS_PAGE32);
    endfunction

    // Apply one request to the mirror and return the answer it should give
    function automatic outcome_t apply_request(input logic [1:0] act, input logic [111:0] req);
        outcome_t    o;
        logic [31:0] seg_base;
        logic [31:0] seg_limit;
        logic [11:0] idx;
        logic [15:0] sel;
        logic [7:0]  acc;
        logic [7:0]  flg;
        int          s;
        int          pick;
        int          entry;
        bit          found;
        seg_base  = req[31:0];
        seg_limit = req[63:32];
        idx       = req[75:64];
        sel       = req[91:76];
        acc       = req[99:92];
        flg       = req[107:100];
        o         = '0;
        o.status  = sda_pkg::ST_OK;
        found     = 1'b0;
        pick      = 0;
        case (act)
            sda_pkg::ACT_ALLOC: begin
                // Lowest free slot whose data entry still fits in the table
                for (s = 0; s < SLOT_COUNT && 2 * s + 7 < TABLE_ENTRIES && !found; s++) begin
                    if (!slot_taken[SAW'(s)]) begin
                        found = 1'b1;
                        pick  = s;
                    end
                end
                if (found) begin
                    gdt[TAW'(2 * pick + 6)] = build_descriptor(seg_base, seg_limit,
                                                               sda_pkg::ACC_USER_CODE,
                                                               sda_pkg::FLAGS_PAGE32);
                    gdt[TAW'(2 * pick + 7)] = build_descriptor(seg_base, seg_limit,
                                                               sda_pkg::ACC_USER_DATA,
                                                               sda_pkg::FLAGS_PAGE32);
                    slot_taken[SAW'(pick)] = 1'b1;
                    o.slot                 = 11'(pick);
                end else begin
                    o.status = sda_pkg::ST_FULL;
                end
            end
            sda_pkg::ACT_FREE: begin
                if (int'(idx) < SLOT_COUNT) begin
                    slot_taken[SAW'(idx)] = 1'b0;
                end else begin
                    o.status = sda_pkg::ST_RANGE;
                end
            end
            sda_pkg::ACT_READ: begin
                entry = int'(sel >> 3);
                if (entry < TABLE_ENTRIES) begin
                    o.base_out = {gdt[TAW'(entry)][63:56], gdt[TAW'(entry)][39:16]};
                end else begin
                    o.status = sda_pkg::ST_RANGE;
                end
            end
            default: begin
                if (int'(idx) < TABLE_ENTRIES) begin
                    gdt[TAW'(idx)] = build_descriptor(seg_base, seg_limit, acc, flg);
                end else begin
                    o.status = sda_pkg::ST_RANGE;
                end
            end
        endcase
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result transfer, then record the outcome of each request transfer
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            clear_model();
            awaited_outcomes.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result transfer %h with no request outstanding", m_tdata);
                    mismatches++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
                    check_field("slot", 32'(want.slot), 32'(m_tdata[12:2]));
                    check_field("base_out", want.base_out, m_tdata[44:13]);
                    results_seen++;
                    if (want.status == sda_pkg::ST_FULL) full_answers++;
                    if (want.status == sda_pkg::ST_RANGE) range_answers++;
                end
            end
            if (s_tvalid && s_tready) begin
                want = apply_request(s_tuser, s_tdata);
                if (s_tuser == sda_pkg::ACT_ALLOC && want.status == sda_pkg::ST_OK) begin
                    slots_granted++;
                end
                awaited_outcomes.push_back(want);
            end
        end
        pending = awaited_outcomes.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the segment descriptor allocator testbench: clock, reset, stimulus and verdict
module tb;

    localparam int SLOTS        = 2045;
    localparam int ENTRIES      = 4096;
    localparam int RANDOM_ITEMS = 300;
    localparam int BURST_ALLOCS = 400;
    localparam int TAIL_ITEMS   = 75;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 500000;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = sda_pkg::ACT_ALLOC;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;

    int mismatches;
    int pending;
    int results_seen;
    int slots_granted;
    int full_answers;
    int range_answers;

    // Percentage of cycles in which each side holds off
    int send_idle = 0;
    int recv_idle = 0;
    int cycle_count = 0;

    segment_descriptor_allocator #(
        .SLOT_COUNT    (SLOTS),
        .TABLE_ENTRIES (ENTRIES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sda_checker #(
        .SLOT_COUNT    (SLOTS),
        .TABLE_ENTRIES (ENTRIES)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .slots_granted (slots_granted),
        .full_answers  (full_answers),
        .range_answers (range_answers)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Abandon a run that hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request after a random gap and hold it until the transfer
    task automatic send_item(input logic [1:0] act, input logic [31:0] seg_base,
                             input logic [31:0] seg_limit, input logic [31:0] idx,
                             input logic [31:0] sel, input logic [31:0] acc,
                             input logic [31:0] flg);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, flg[7:0], acc[7:0], sel[15:0], idx[11:0], seg_limit, seg_base};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Read the base behind one selector, other fields random
    task automatic send_read(input logic [31:0] sel);
        send_item(sda_pkg::ACT_READ, $urandom(), $urandom(), $urandom(), sel, $urandom(),
                  $urandom());
    endtask

    // Random request, aimed mostly at the low slots and entries where allocation happens
    task automatic send_random();
        int          pick;
        int          r;
        logic [1:0]  act;
        logic [31:0] idx;
        logic [31:0] sel;
        pick = $urandom_range(99);
        r    = $urandom_range(99);
        idx  = $urandom();
        sel  = $urandom();
        if (pick < 35) act = sda_pkg::ACT_ALLOC;
        else if (pick < 60) act = sda_pkg::ACT_FREE;
        else if (pick < 85) act = sda_pkg::ACT_READ;
        else act = sda_pkg::ACT_WRITE;
        case (act)
            sda_pkg::ACT_FREE: begin
                if (r < 60) idx = $urandom_range(63);
                else if (r < 85) idx = $urandom_range(SLOTS - 1);
            end
            sda_pkg::ACT_READ: begin
                if (r < 70) sel = ($urandom_range(200) << 3) | $urandom_range(7);
            end
            sda_pkg::ACT_WRITE: begin
                if (r < 50) idx = $urandom_range(200);
            end
            default: begin
            end
        endcase
        send_item(act, $urandom(), $urandom(), idx, sel, $urandom(), $urandom());
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Sender idles lightly, receiver heavily
        send_idle = 26;
        recv_idle = 82;

        // Flat entries, entry zero and the table edge
        send_read(32'h0000);
        send_read(32'h000B);
        send_read(32'h0010);
        send_read(32'h001B);
        send_read(32'h0023);
        send_read(32'h7FFF);
        send_read(32'h8000);
        send_read(32'hFFFF);

        // Allocate with extreme bases and limits, then read back an entry of two pairs
        send_item(sda_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFF, 32'hFFFF, 32'hFF,
                  32'hFF);
        send_item(sda_pkg::ACT_ALLOC, 32'h0000_0000, 32'h0000_0000, 32'h000, 32'h0000, 32'h00,
                  32'h00);
        send_item(sda_pkg::ACT_ALLOC, 32'h1234_5678, 32'h000A_BCDE, $urandom(), $urandom(),
                  $urandom(), $urandom());
        send_read(32'h0033);
        send_read(32'h0048);

        // Free a used slot, the same slot again, the top slot and two out of range
        send_item(sda_pkg::ACT_FREE, $urandom(), $urandom(), 32'd0, $urandom(), $urandom(),
                  $urandom());
        send_item(sda_pkg::ACT_FREE, $urandom(), $urandom(), 32'd0, $urandom(), $urandom(),
                  $urandom());
        send_item(sda_pkg::ACT_FREE, $urandom(), $urandom(), 32'(SLOTS - 1), $urandom(),
                  $urandom(), $urandom());
        send_item(sda_pkg::ACT_FREE, $urandom(), $urandom(), 32'(SLOTS), $urandom(),
                  $urandom(), $urandom());
        send_item(sda_pkg::ACT_FREE, $urandom(), $urandom(), 32'hFFF, $urandom(), $urandom(),
                  $urandom());
        send_item(sda_pkg::ACT_ALLOC, 32'hA5A5_5A5A, 32'hFFF0_0001, $urandom(), $urandom(),
                  $urandom(), $urandom());

        // Overwrite entry zero, a flat entry and the last entry, then read them
        send_item(sda_pkg::ACT_WRITE, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'd0, $urandom(), 32'hFF,
                  32'hFF);
        send_item(sda_pkg::ACT_WRITE, 32'h0000_0000, 32'h0000_0000, 32'd1, $urandom(), 32'h00,
                  32'h00);
        send_item(sda_pkg::ACT_WRITE, 32'h8765_4321, $urandom(), 32'hFFF, $urandom(),
                  $urandom(), $urandom());
        send_read(32'h0004);
        send_read(32'h0008);
        send_read(32'h7FF8);

        repeat (RANDOM_ITEMS) send_random();

        // Sender idles heavily, receiver lightly
        send_idle = 82;
        recv_idle = 26;
        repeat (RANDOM_ITEMS) send_random();

        // No idling: a long run of allocations back to back, then mixed traffic
        send_idle = 0;
        recv_idle = 0;
        repeat (BURST_ALLOCS) begin
            send_item(sda_pkg::ACT_ALLOC, $urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom());
        end
        repeat (TAIL_ITEMS) send_random();
        s_tvalid <= 1'b0;

        // Drain outstanding results
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Checked %0d results: %0d slots granted, %0d table-full, %0d out-of-range.",
                 results_seen, slots_granted, full_answers, range_answers);
        $display("Three pacing phases, directed edge cases and an allocation burst were run.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/sda_pkg.sv
sv/sda_ram.sv
sv/sda_slot_map.sv
sv/segment_descriptor_allocator.sv
verif/sda_checker.sv
verif/tb.sv
